// ===== rtl/ttps_pkg.sv =====
`timescale 1ns / 1ps

package ttps_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 1024;

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned DEPTH_W = 7;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned BOUND_W = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// Bound kinds
	localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
	localparam logic [BOUND_W-1:0] BOUND_ALPHA = 2'd1;
	localparam logic [BOUND_W-1:0] BOUND_BETA  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]          tag;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] score;
		logic [BOUND_W-1:0]        bound;
	} entry_t;

endpackage

// ===== rtl/ttps_ram.sv =====
`timescale 1ns / 1ps

module ttps_ram #(
	parameter int unsigned Depth = 1024,
	parameter int unsigned Width = 8,
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/transposition_table_probe_store.sv =====
`timescale 1ns / 1ps
// Lookup and store: with a power-of-two entry count an accepted item reads the entry
// memory, then is compared and written back in the evaluate state; otherwise the key
// reduction (four partial products, then the remainder) and a separate memory read come
// first. A new request is taken only after the last result goes to the output register.
// A clear request sweeps the entry memory with zeros, then gives its result.
// After reset the same sweep runs before the first transfer.

module transposition_table_probe_store import ttps_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [REQ_W-1:0]          req_type,
	input  logic [KEY_W-1:0]          pos_key,
	input  logic [DEPTH_W-1:0]        search_depth,
	input  logic signed [SCORE_W-1:0] lower_window,
	input  logic signed [SCORE_W-1:0] upper_window,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [BOUND_W-1:0]        bound_kind,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      found,
	output logic signed [SCORE_W-1:0] result_score,
	output logic                      written
);

	localparam int unsigned IdxW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam bit          IsPow2  = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
	localparam int unsigned EntW    = $bits(entry_t);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic       clr_req_q;
	logic [IdxW-1:0] clr_cnt_q;

	logic [REQ_W-1:0]          req_q;
	logic [KEY_W-1:0]          key_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic signed [SCORE_W-1:0] alpha_q;
	logic signed [SCORE_W-1:0] beta_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [BOUND_W-1:0]        bound_q;
	logic [IdxW-1:0]           idx_q;

	logic                      out_valid_q;
	logic                      found_q;
	logic signed [SCORE_W-1:0] res_score_q;
	logic                      written_q;

	logic            in_acc;
	logic            acc_probe;
	logic            eval_go;
	logic [IdxW-1:0] idx_in;
	logic [IdxW-1:0] mod_idx;
	logic            mod_done;

	logic            ram_we;
	logic [IdxW-1:0] ram_waddr;
	logic [EntW-1:0] ram_wdata;
	logic            ram_re;
	logic [IdxW-1:0] ram_raddr;
	logic [EntW-1:0] ram_rdata;
	entry_t          ent;
	entry_t          new_ent;

	logic hit_base;
	logic hit;
	logic signed [SCORE_W-1:0] hit_score;
	logic do_write;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign acc_probe = in_acc && ((req_type == REQ_LOOKUP) || (req_type == REQ_STORE));
	assign eval_go   = !out_valid_q || !out_stall;

	// Entry index: key modulo the entry count
	generate
		if (IsPow2) begin : g_idx_mask
			if (TABLE_ENTRIES > 1) begin : g_bits
				assign idx_in = pos_key[IdxW-1:0];
			end else begin : g_single
				assign idx_in = '0;
			end
			assign mod_idx  = '0;
			assign mod_done = 1'b1;
		end else begin : g_idx_mod
			localparam int unsigned LimbW    = KEY_W / 2;
			localparam int unsigned AccW     = 2 * KEY_W + 1;
			localparam int unsigned ModSteps = 5;
			localparam int unsigned McntW    = $clog2(ModSteps);
			localparam logic [2*KEY_W-1:0] MagNum = (2*KEY_W)'(1) << (KEY_W + IdxW);
			localparam logic [2*KEY_W-1:0] MagFull =
				(MagNum + (2*KEY_W)'(TABLE_ENTRIES) - (2*KEY_W)'(1)) /
				(2*KEY_W)'(TABLE_ENTRIES);
			localparam logic [KEY_W:0]  Mag = MagFull[KEY_W:0];
			localparam logic [IdxW:0]   NW  = (IdxW + 1)'(TABLE_ENTRIES);
			logic [AccW-1:0]    acc_q;
			logic [McntW-1:0]   mcnt_q;
			logic [LimbW-1:0]   key_limb;
			logic [LimbW-1:0]   mag_limb;
			logic [2*LimbW-1:0] part;
			logic [AccW-1:0]    part_sh;
			logic [IdxW:0]      quo_lo;
			logic [IdxW:0]      rem_w;

			// The quotient is the top of the key times the rounded-up reciprocal, which is
			// exact for every 64-bit key. It is built from four 32 by 32 partial products,
			// one a cycle; the remainder then needs only the low bits of the quotient.
			always_comb begin
				key_limb = mcnt_q[1] ? key_q[2*LimbW-1:LimbW] : key_q[LimbW-1:0];
				mag_limb = mcnt_q[0] ? Mag[2*LimbW-1:LimbW] : Mag[LimbW-1:0];
				part     = key_limb * mag_limb;
				part_sh  = AccW'(part) << (LimbW * (32'(mcnt_q[1]) + 32'(mcnt_q[0])));
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mcnt_q <= '0;
				end else if (in_acc) begin
					mcnt_q <= '0;
				end else if (state_q == S_MOD) begin
					mcnt_q <= mcnt_q + 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (in_acc) begin
					acc_q <= Mag[KEY_W] ? (AccW'(pos_key) << KEY_W) : '0;
				end else if (state_q == S_MOD && !mod_done) begin
					acc_q <= acc_q + part_sh;
				end
			end

			assign quo_lo   = acc_q[KEY_W + IdxW +: IdxW + 1];
			assign rem_w    = key_q[IdxW:0] - (IdxW + 1)'(quo_lo * NW);
			assign idx_in   = '0;
			assign mod_idx  = rem_w[IdxW-1:0];
			assign mod_done = (mcnt_q == McntW'(ModSteps - 1));
		end
	endgenerate

	// Memory access
	assign ram_re    = (acc_probe && IsPow2) || (state_q == S_READ);
	assign ram_raddr = (state_q == S_READ) ? idx_q : idx_in;

	assign new_ent.tag   = key_q;
	assign new_ent.depth = depth_q;
	assign new_ent.score = score_q;
	assign new_ent.bound = bound_q;

	assign ent = entry_t'(ram_rdata);

	assign do_write = (req_q == REQ_STORE) && (ent.depth <= depth_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = EntW'(new_ent);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (state_q == S_EVAL && eval_go && do_write) begin
			ram_we = 1'b1;
		end
	end

	ttps_ram #(
		.Depth(TABLE_ENTRIES),
		.Width(EntW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Lookup decision on the entry just read
	assign hit_base = (ent.tag == key_q) && (key_q != '0) && (ent.score != '0) &&
		(ent.depth >= depth_q);

	always_comb begin
		hit       = 1'b0;
		hit_score = '0;
		if (hit_base) begin
			if (ent.bound == BOUND_EXACT) begin
				hit       = 1'b1;
				hit_score = ent.score;
			end else if (ent.bound == BOUND_ALPHA && ent.score <= alpha_q) begin
				hit       = 1'b1;
				hit_score = alpha_q;
			end else if (ent.bound == BOUND_BETA && ent.score >= beta_q) begin
				hit       = 1'b1;
				hit_score = beta_q;
			end
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q   <= req_type;
			key_q   <= pos_key;
			depth_q <= search_depth;
			alpha_q <= lower_window;
			beta_q  <= upper_window;
			score_q <= new_score;
			bound_q <= bound_kind;
			idx_q   <= idx_in;
		end else if (state_q == S_MOD && mod_done) begin
			idx_q <= mod_idx;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_req_q <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_cnt_q == IdxW'(TABLE_ENTRIES - 1)) begin
						state_q   <= clr_req_q ? S_DONE : S_IDLE;
						clr_cnt_q <= '0;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (req_type == REQ_CLEAR) begin
							state_q   <= S_CLEAR;
							clr_req_q <= 1'b1;
							clr_cnt_q <= '0;
						end else if (acc_probe) begin
							state_q <= IsPow2 ? S_EVAL : S_MOD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL, S_DONE: begin
					if (eval_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: a finished result waits here while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EVAL || state_q == S_DONE) && eval_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL && eval_go) begin
			found_q     <= (req_q == REQ_LOOKUP) && hit;
			res_score_q <= ((req_q == REQ_LOOKUP) && hit) ? hit_score : '0;
			written_q   <= do_write;
		end else if (state_q == S_DONE && eval_go) begin
			found_q     <= 1'b0;
			res_score_q <= '0;
			written_q   <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign result_score = res_score_q;
	assign written      = written_q;

`ifndef SYNTHESIS
	a_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EVAL || $past(state_q) == S_DONE))
		else $error("result raised outside a finishing state");

	a_clear_writes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (ram_we && ram_wdata == '0 && !ram_re))
		else $error("clear sweep does not write zeros");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("memory read and write in the same cycle");

	a_written_store_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && eval_go && req_q != REQ_STORE) |=> !written_q)
		else $error("written flagged for a request that is not a store");

	a_found_lookup_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && eval_go && req_q != REQ_LOOKUP) |=> !found_q)
		else $error("found flagged for a request that is not a lookup");
`endif

endmodule

// ===== bench/transposition_table_probe_store_tb.sv =====
`timescale 1ns / 1ps

module transposition_table_probe_store_tb;
	import ttps_pkg::*;

	localparam int unsigned TABLE_ENTRIES   = TABLE_ENTRIES_DEF;
	localparam int          DIRECTED_COUNT  = 25;
	localparam int          RANDOM_ITEMS    = 800;
	localparam int          QUIET_TAIL      = 80;
	localparam int          HOLD_OFF_AT     = 250;
	localparam int          HOLD_OFF_CYCLES = 400;
	localparam int          POOL_SIZE       = 16;
	localparam int          DRAIN_LIMIT     = 5000;
	localparam int          SETTLE_CYCLES   = 20;
	localparam int          CYCLE_LIMIT     = 300000;
	localparam int          PRINT_LIMIT     = 30;

	localparam logic [REQ_W-1:0]   REQ_UNUSED   = 2'd3;
	localparam logic [BOUND_W-1:0] BOUND_UNUSED = 2'd3;

	localparam logic [KEY_W-1:0] KEY_ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_ALIAS      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_ONE        = 64'h0000_0000_0000_0001;
	localparam logic [KEY_W-1:0] KEY_TOP        = 64'h8000_0000_0000_0200;
	localparam logic [KEY_W-1:0] KEY_MIXED      = 64'h0123_4567_89AB_CDEF;
	localparam logic [KEY_W-1:0] KEY_ZERO_SCORE = 64'hFEDC_BA98_7654_3210;
	localparam logic [KEY_W-1:0] KEY_NONE       = 64'h0;

	typedef struct packed {
		logic                      found;
		logic signed [SCORE_W-1:0] score;
		logic                      written;
	} probe_outcome_t;

	typedef struct packed {
		logic [REQ_W-1:0]          req;
		logic [KEY_W-1:0]          key;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] alpha;
		logic signed [SCORE_W-1:0] beta;
		logic signed [SCORE_W-1:0] score;
		logic [BOUND_W-1:0]        bound;
		logic                      has_literal;
		probe_outcome_t            literal;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [REQ_W-1:0]          req_type;
	logic [KEY_W-1:0]          pos_key;
	logic [DEPTH_W-1:0]        search_depth;
	logic signed [SCORE_W-1:0] lower_window;
	logic signed [SCORE_W-1:0] upper_window;
	logic signed [SCORE_W-1:0] new_score;
	logic [BOUND_W-1:0]        bound_kind;
	logic                      out_valid;
	logic                      out_stall;
	logic                      found;
	logic signed [SCORE_W-1:0] result_score;
	logic                      written;

	// Shadow copy of the entry memory.
	logic [KEY_W-1:0]          tt_tag   [TABLE_ENTRIES];
	logic [DEPTH_W-1:0]        tt_depth [TABLE_ENTRIES];
	logic signed [SCORE_W-1:0] tt_score [TABLE_ENTRIES];
	logic [BOUND_W-1:0]        tt_bound [TABLE_ENTRIES];

	probe_outcome_t   pending_outcomes [$];
	stim_row_t        directed_rows [DIRECTED_COUNT];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int  mismatches    = 0;
	int  items_sent    = 0;
	int  results_seen  = 0;
	int  lookup_hits   = 0;
	int  stores_done   = 0;
	int  clears_done   = 0;
	int  cycle_count   = 0;
	bit  quiet         = 1'b0;
	bit  hold_off_req  = 1'b0;
	bit  hold_off_done = 1'b0;

	transposition_table_probe_store dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.pos_key      (pos_key),
		.search_depth (search_depth),
		.lower_window (lower_window),
		.upper_window (upper_window),
		.new_score    (new_score),
		.bound_kind   (bound_kind),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.result_score (result_score),
		.written      (written)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("tb: mismatch %0d at %0t: %s", mismatches, $realtime, msg);
		end
	endtask

	function automatic void clear_table();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tt_tag[i]   = '0;
			tt_depth[i] = '0;
			tt_score[i] = '0;
			tt_bound[i] = '0;
		end
	endfunction

	function automatic probe_outcome_t predict_probe_store(input stim_row_t r);
		probe_outcome_t            o;
		int unsigned               idx;
		logic signed [SCORE_W-1:0] s;
		logic signed [SCORE_W-1:0] alpha;
		logic signed [SCORE_W-1:0] beta;
		o     = '0;
		idx   = int'(r.key % TABLE_ENTRIES);
		s     = tt_score[idx];
		alpha = r.alpha;
		beta  = r.beta;
		case (r.req)
			REQ_LOOKUP: begin
				if (tt_tag[idx] == r.key && r.key != '0 && s != 0 && tt_depth[idx] >= r.depth) begin
					if (tt_bound[idx] == BOUND_EXACT) begin
						o.found = 1'b1;
						o.score = s;
					end else if (tt_bound[idx] == BOUND_ALPHA && s <= alpha) begin
						o.found = 1'b1;
						o.score = alpha;
					end else if (tt_bound[idx] == BOUND_BETA && s >= beta) begin
						o.found = 1'b1;
						o.score = beta;
					end
				end
			end
			REQ_STORE: begin
				if (tt_depth[idx] <= r.depth) begin
					tt_tag[idx]   = r.key;
					tt_depth[idx] = r.depth;
					tt_score[idx] = r.score;
					tt_bound[idx] = r.bound;
					o.written     = 1'b1;
				end
			end
			REQ_CLEAR: begin
				clear_table();
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic stim_row_t mk_row(
		input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
		input logic [DEPTH_W-1:0] depth, input logic signed [SCORE_W-1:0] alpha,
		input logic signed [SCORE_W-1:0] beta, input logic signed [SCORE_W-1:0] score,
		input logic [BOUND_W-1:0] bound, input logic has_literal, input logic f,
		input logic signed [SCORE_W-1:0] s, input logic w);
		stim_row_t r;
		r.req         = req;
		r.key         = key;
		r.depth       = depth;
		r.alpha       = alpha;
		r.beta        = beta;
		r.score       = score;
		r.bound       = bound;
		r.has_literal = has_literal;
		r.literal     = '{found: f, score: s, written: w};
		return r;
	endfunction

	function automatic logic signed [SCORE_W-1:0] window_near(input int base);
		return SCORE_W'(base + int'($urandom_range(0, 40)) - 20);
	endfunction

	function automatic stim_row_t random_request();
		stim_row_t r;
		int        pick;
		int        base;
		r.req         = REQ_LOOKUP;
		r.key         = {$urandom, $urandom};
		r.depth       = DEPTH_W'($urandom);
		r.alpha       = SCORE_W'($urandom);
		r.beta        = SCORE_W'($urandom);
		r.score       = SCORE_W'($urandom);
		r.bound       = BOUND_W'($urandom);
		r.has_literal = 1'b0;
		r.literal     = '0;
		pick          = $urandom_range(0, 99);
		if (pick < 2) begin
			r.req = REQ_CLEAR;
		end else if (pick < 5) begin
			r.req = REQ_UNUSED;
		end else if (pick < 12) begin
			r.req = REQ_W'($urandom);
		end else begin
			// Well-formed traffic on a small set of keys that share a few entries,
			// so that hits, replacements and tag mismatches all come up often.
			r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			if ($urandom_range(0, 9) != 0) begin
				r.depth = DEPTH_W'($urandom_range(0, 12));
			end
			if ($urandom_range(0, 99) < 45) begin
				r.req = REQ_STORE;
				if ($urandom_range(0, 9) != 0) begin
					base    = int'($urandom_range(1, 300));
					r.score = SCORE_W'($urandom_range(0, 1) ? base : -base);
				end
				r.bound = ($urandom_range(0, 15) == 0) ? BOUND_UNUSED :
					BOUND_W'($urandom_range(0, 2));
			end else begin
				base = tt_score[int'(r.key % TABLE_ENTRIES)];
				if ($urandom_range(0, 6) != 0) begin
					r.alpha = window_near(base);
					r.beta  = window_near(base);
				end
			end
		end
		return r;
	endfunction

	task automatic offer_request(input stim_row_t r);
		probe_outcome_t o;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		req_type     <= r.req;
		pos_key      <= r.key;
		search_depth <= r.depth;
		lower_window <= r.alpha;
		upper_window <= r.beta;
		new_score    <= r.score;
		bound_kind   <= r.bound;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// The shadow table must follow every transfer, typed rows included.
		o = predict_probe_store(r);
		if (r.has_literal) begin
			o = r.literal;
		end
		pending_outcomes.push_back(o);
		items_sent++;
		if (o.found) lookup_hits++;
		if (o.written) stores_done++;
		if (r.req == REQ_CLEAR) clears_done++;
	endtask

	always @(posedge clk) begin : check_result
		probe_outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_outcomes.pop_front();
				if (found !== want.found) begin
					report_mismatch($sformatf("found %b, expected %b", found, want.found));
				end
				if (result_score !== want.score) begin
					report_mismatch($sformatf("result_score %0d, expected %0d",
						result_score, want.score));
				end
				if (written !== want.written) begin
					report_mismatch($sformatf("written %b, expected %b", written, want.written));
				end
			end
		end
	end

	initial begin : result_side
		int held;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				// Long hold-off while the sender keeps offering, to back the block up.
				hold_off_done = 1'b1;
				out_stall <= 1'b1;
				for (held = 1; held < HOLD_OFF_CYCLES; held++) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: timeout after %0d cycles", cycle_count);
		$display("tb: failure");
		$finish;
	end

	initial begin : request_side
		int drain_cycles;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_LOOKUP;
		pos_key      = '0;
		search_depth = '0;
		lower_window = '0;
		upper_window = '0;
		new_score    = '0;
		bound_kind   = BOUND_EXACT;
		drain_cycles = 0;
		clear_table();

		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i]      = {$urandom, $urandom};
			key_pool[i][9:0] = 10'($urandom_range(0, 5) * 171);
		end
		key_pool[0] = KEY_NONE;

		// Only the obvious outcomes are typed in; the rest go through the predictor.
		directed_rows[0]  = mk_row(REQ_LOOKUP, KEY_ALL_ONES, 0, -32768, 32767, 0,
			BOUND_EXACT, 1, 0, 0, 0);
		directed_rows[1]  = mk_row(REQ_LOOKUP, KEY_NONE, 0, 0, 0, 0, BOUND_EXACT, 1, 0, 0, 0);
		directed_rows[2]  = mk_row(REQ_STORE, KEY_ALL_ONES, 5, 0, 0, 100, BOUND_EXACT,
			1, 0, 0, 1);
		directed_rows[3]  = mk_row(REQ_LOOKUP, KEY_ALL_ONES, 5, -1, 1, 0, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[4]  = mk_row(REQ_LOOKUP, KEY_ALL_ONES, 6, -1, 1, 0, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[5]  = mk_row(REQ_STORE, KEY_ALL_ONES, 4, 0, 0, 7, BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[6]  = mk_row(REQ_STORE, KEY_ALL_ONES, 127, 0, 0, 32767, BOUND_EXACT,
			1, 0, 0, 1);
		directed_rows[7]  = mk_row(REQ_LOOKUP, KEY_ALL_ONES, 0, -32768, 32767, 0,
			BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[8]  = mk_row(REQ_STORE, KEY_ONE, 3, 0, 0, -32768, BOUND_ALPHA,
			0, 0, 0, 0);
		directed_rows[9]  = mk_row(REQ_LOOKUP, KEY_ONE, 3, 32767, 0, 0, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[10] = mk_row(REQ_LOOKUP, KEY_ONE, 0, -32768, 0, 0, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[11] = mk_row(REQ_STORE, KEY_TOP, 2, 0, 0, 50, BOUND_BETA, 0, 0, 0, 0);
		directed_rows[12] = mk_row(REQ_LOOKUP, KEY_TOP, 2, 0, 50, 0, BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[13] = mk_row(REQ_LOOKUP, KEY_TOP, 2, 0, 51, 0, BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[14] = mk_row(REQ_STORE, KEY_MIXED, 1, 0, 0, 9, BOUND_UNUSED,
			0, 0, 0, 0);
		directed_rows[15] = mk_row(REQ_LOOKUP, KEY_MIXED, 1, -32768, 32767, 0, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[16] = mk_row(REQ_STORE, KEY_ZERO_SCORE, 1, 0, 0, 0, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[17] = mk_row(REQ_LOOKUP, KEY_ZERO_SCORE, 0, -32768, 32767, 0,
			BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[18] = mk_row(REQ_STORE, KEY_NONE, 10, 0, 0, 33, BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[19] = mk_row(REQ_LOOKUP, KEY_NONE, 0, -32768, 32767, 0, BOUND_EXACT,
			1, 0, 0, 0);
		directed_rows[20] = mk_row(REQ_STORE, KEY_ALIAS, 127, 0, 0, -5, BOUND_EXACT,
			0, 0, 0, 0);
		directed_rows[21] = mk_row(REQ_LOOKUP, KEY_ALL_ONES, 0, -32768, 32767, 0,
			BOUND_EXACT, 0, 0, 0, 0);
		directed_rows[22] = mk_row(REQ_UNUSED, KEY_ALL_ONES, 127, -1, -1, -1, BOUND_UNUSED,
			1, 0, 0, 0);
		directed_rows[23] = mk_row(REQ_CLEAR, KEY_ALL_ONES, 127, -1, -1, -1, BOUND_UNUSED,
			1, 0, 0, 0);
		directed_rows[24] = mk_row(REQ_LOOKUP, KEY_ALIAS, 0, -32768, 32767, 0, BOUND_EXACT,
			1, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			offer_request(directed_rows[i]);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_OFF_AT) hold_off_req = 1'b1;
			if (i >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
			offer_request(random_request());
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending_outcomes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_outcomes.size()));
		end

		$display("tb: %0d requests sent, %0d results checked, %0d mismatches",
			items_sent, results_seen, mismatches);
		$display("tb: %0d lookup hits, %0d stores written, %0d table clears",
			lookup_hits, stores_done, clears_done);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
